@@ src/double_ended_queue_assert.svh @@
// Assertion macros for the double-ended queue.
// Used by the checker; depends on nothing else.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Clocked assertion that is switched off while reset is active.
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is active.
`define DEQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/deq_pkg.sv @@
// Shared constants, codes and types of the double-ended queue.
// Used by the interfaces, the cell, the top level and the checker.
package deq_pkg;

  // Number of entries the queue holds.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OCC_W   = 5;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [OCC_W-1:0] occ_t;

  // Operation codes.
  localparam op_t OP_PUSH_FRONT = 2'd0;
  localparam op_t OP_PUSH_BACK  = 2'd1;
  localparam op_t OP_POP_FRONT  = 2'd2;
  localparam op_t OP_POP_BACK   = 2'd3;

  // Status codes.
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_UNDERFLOW = 2'd1;
  localparam status_t ST_OVERFLOW  = 2'd2;

  // Per-cell update controls; at most one is set in a cycle.
  typedef struct packed {
    logic take_left;   // shift toward the back, take the left neighbor
    logic take_right;  // shift toward the front, take the right neighbor
    logic load;        // store the pushed word
  } deq_cell_ctrl_t;

endpackage

@@ src/deq_if.sv @@
// Valid/ready channels of the double-ended queue: request and response.
// Depends on deq_pkg.
interface deq_req_if import deq_pkg::*; ();
  logic   valid;
  logic   ready;
  op_t    op;
  value_t value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
  logic    valid;
  logic    ready;
  value_t  popped_value;
  status_t status;
  occ_t    occupancy;

  modport source (output valid, output popped_value, output status, output occupancy,
                  input ready);
  modport sink (input valid, input popped_value, input status, input occupancy,
                output ready);
endinterface

@@ src/deq_cell.sv @@
// One storage cell of the queue row: holds one word and shifts with its neighbors.
// Depends on deq_pkg.
module deq_cell import deq_pkg::*; (
  input  logic           clk_i,
  input  deq_cell_ctrl_t ctrl_i,
  input  value_t         left_i,
  input  value_t         right_i,
  input  value_t         load_i,
  output value_t         data_o
);

  value_t data_q;
  value_t data_d;

  // Pick the next word: left neighbor, right neighbor, pushed word or hold.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.take_left) begin
      data_d = left_i;
    end else if (ctrl_i.take_right) begin
      data_d = right_i;
    end else if (ctrl_i.load) begin
      data_d = load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ src/double_ended_queue.sv @@
// Bounded double-ended queue of DEPTH signed 32-bit words, kept as a row of cells with the
// front word always in the first cell. It takes one operation per clock cycle: push front
// shifts the row one cell toward the back, pop front shifts it toward the front, push back
// writes the cell just past the last word and pop back reads the last word through a mux
// over the row. Each operation gives one result in the next cycle from an output register;
// the request side stays ready while that result is taken in the same cycle, so a
// consumer that never stalls sees one result per cycle. A push on a full queue reports
// overflow and a pop on an empty queue reports underflow; neither changes the contents.
// No clearing pass is needed after reset: the queue starts empty.
module double_ended_queue import deq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q;
  value_t           popped_q, popped_d;
  status_t          status_q, status_d;
  occ_t             occ_q;

  logic             accept;
  logic             full;
  logic             empty;
  logic             do_push_front, do_push_back, do_pop_front;
  logic [CNT_W-1:0] last_pos;
  value_t           cell_data [DEPTH];

  assign accept = req_i.valid && req_i.ready;
  assign full   = (cnt_q == CNT_W'(DEPTH));
  assign empty  = (cnt_q == '0);

  // Position of the last word, valid whenever the queue is not empty.
  assign last_pos = cnt_q - CNT_W'(1);

  // Decode the operation into row moves and the result.
  // A pop at the back only shrinks the count; the row itself stays put.
  always_comb begin
    do_push_front = 1'b0;
    do_push_back  = 1'b0;
    do_pop_front  = 1'b0;
    popped_d      = '0;
    status_d      = ST_OK;
    cnt_d         = cnt_q;
    unique case (req_i.op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          do_push_front = accept && (req_i.op == OP_PUSH_FRONT);
          do_push_back  = accept && (req_i.op == OP_PUSH_BACK);
          cnt_d         = cnt_q + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else begin
          do_pop_front = accept;
          popped_d     = cell_data[0];
          cnt_d        = cnt_q - CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else begin
          popped_d    = cell_data[last_pos[IDX_W-1:0]];
          cnt_d       = cnt_q - CNT_W'(1);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Row of storage cells; each one trades words with its neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deq_cell_ctrl_t ctrl;
    value_t         left_data;
    value_t         right_data;

    assign ctrl.take_left  = do_push_front;
    assign ctrl.take_right = do_pop_front;
    assign ctrl.load       = do_push_back && (cnt_q == CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_data = req_i.value;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    deq_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left_data),
      .right_i(right_data),
      .load_i (req_i.value),
      .data_o (cell_data[i])
    );
  end

  // Occupancy count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
      occ_q    <= OCC_W'(cnt_d);
    end
  end

  assign req_i.ready        = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.popped_value = popped_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.occupancy    = occ_q;

endmodule

@@ src/deq_checker.sv @@
// Port-level checks on the double-ended queue, bound to its top level.
// Depends on deq_pkg and double_ended_queue_assert.svh.
`include "double_ended_queue_assert.svh"

module deq_checker import deq_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    rsp_valid_i,
  input logic    rsp_ready_i,
  input value_t  popped_value_i,
  input status_t status_i,
  input occ_t    occupancy_i
);

  // No result is offered while reset is active.
  `DEQ_ASSERT_ALWAYS(a_no_valid_in_reset, clk_i, !rst_ni |-> !rsp_valid_i, "result during reset")

  // An underflow only happens on an empty queue and returns no word.
  `DEQ_ASSERT(a_underflow_empty, clk_i, rst_ni, (rsp_valid_i && status_i == ST_UNDERFLOW) |-> (occupancy_i == '0 && popped_value_i == '0), "bad underflow result")

  // An overflow only happens on a full queue and returns no word.
  `DEQ_ASSERT(a_overflow_full, clk_i, rst_ni, (rsp_valid_i && status_i == ST_OVERFLOW) |-> (occupancy_i == OCC_W'(DEPTH) && popped_value_i == '0), "bad overflow result")

  // A stalled result holds until it is taken.
  `DEQ_ASSERT(a_rsp_hold, clk_i, rst_ni, (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(popped_value_i) && $stable(status_i) && $stable(occupancy_i)), "stalled result changed")

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .popped_value_i(rsp_o.popped_value),
  .status_i      (rsp_o.status),
  .occupancy_i   (rsp_o.occupancy)
);

@@ dv/tb_double_ended_queue.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the bounded double-ended queue.
// Depends on deq_pkg, the deq_req_if/deq_rsp_if interfaces and double_ended_queue.
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;

  typedef struct {
    value_t  popped_value;
    status_t status;
    occ_t    occupancy;
  } deq_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  deq_req_if req ();
  deq_rsp_if rsp ();

  double_ended_queue uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Shadow copy of the queue contents and pointers.
  value_t      shadow_word [DEPTH];
  int unsigned shadow_front;
  int unsigned shadow_back;
  int unsigned shadow_count;

  // Results owed by the block, oldest first.
  deq_result_t op_results_due [$];
  deq_result_t due;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        stall_request;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned overflow_seen;
  int unsigned underflow_seen;
  int unsigned peak_occupancy;

  always #1 clk_i = ~clk_i;

  // Apply one operation to the shadow queue and return the result it owes.
  function automatic deq_result_t deq_shadow_op(input op_t op, input value_t word);
    deq_result_t r;
    r.popped_value = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else if (op == OP_PUSH_FRONT) begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_word[shadow_front] = word;
          shadow_count++;
        end else begin
          shadow_word[shadow_back] = word;
          shadow_back = (shadow_back + 1) % DEPTH;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (op == OP_POP_FRONT) begin
          r.popped_value = shadow_word[shadow_front];
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
        end else begin
          shadow_back = (shadow_back + DEPTH - 1) % DEPTH;
          r.popped_value = shadow_word[shadow_back];
          shadow_count--;
        end
      end
    endcase
    r.occupancy = occ_t'(shadow_count);
    return r;
  endfunction

  // Offer one item, with random idle cycles first, and wait until it is taken.
  task automatic issue_op(input op_t op, input value_t word);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.op    <= op;
    req.value <= word;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    op_results_due.push_back(deq_shadow_op(op, word));
    items_sent++;
  endtask

  // Both pops on an empty queue must report underflow.
  task automatic test_empty_pops();
    issue_op(OP_POP_FRONT, 32'sh1234_5678);
    issue_op(OP_POP_BACK, -32'sd1);
  endtask

  // The largest and smallest words go in at either end and come out again.
  task automatic test_extreme_words();
    issue_op(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
    issue_op(OP_PUSH_BACK, 32'sh8000_0000);
    issue_op(OP_POP_BACK, 32'sd0);
    issue_op(OP_POP_FRONT, 32'sd0);
  endtask

  // Fill the queue from both ends, then push once more at each end.
  task automatic test_fill_to_overflow();
    value_t word;
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: word = 32'sd0;
        1: word = -32'sd1;
        2: word = 32'shAAAA_AAAA;
        default: word = 32'sh5555_5555;
      endcase
      issue_op((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, word);
    end
    issue_op(OP_PUSH_FRONT, 32'sh0BAD_F00D);
    issue_op(OP_PUSH_BACK, 32'sh0BAD_F00D);
  endtask

  // Bursts that lean toward pushes, toward pops or neither, so the queue swings between
  // empty and full with random words.
  task automatic test_random_mix(input int n_items);
    int unsigned push_pct;
    op_t         op;
    value_t      word;
    push_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 16 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: word = 32'sh7FFF_FFFF;
          1: word = 32'sh8000_0000;
          2: word = 32'sd0;
          default: word = -32'sd1;
        endcase
      end else begin
        word = $urandom;
      end
      issue_op(op, word);
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming,
  // so the output register fills and the request side stalls.
  task automatic test_output_backpressure();
    stall_request <= 1'b1;
    test_random_mix(40);
  endtask

  // Response ready: random idling, or a long hold when one is requested.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_request) begin
      rsp.ready     <= 1'b0;
      hold_left     <= HOLD_CYCLES - 1;
      stall_request <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare every accepted result with the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (op_results_due.size() == 0) begin
        $display("%0t: unexpected result: value %0d status %0d occupancy %0d", $time,
                 rsp.popped_value, rsp.status, rsp.occupancy);
        error_count++;
      end else begin
        due = op_results_due.pop_front();
        results_seen++;
        if (rsp.popped_value !== due.popped_value) begin
          $display("%0t: popped_value mismatch: expected %0d, actual %0d", $time,
                   due.popped_value, rsp.popped_value);
          error_count++;
        end
        if (rsp.status !== due.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                   due.status, rsp.status);
          error_count++;
        end
        if (rsp.occupancy !== due.occupancy) begin
          $display("%0t: occupancy mismatch: expected %0d, actual %0d", $time,
                   due.occupancy, rsp.occupancy);
          error_count++;
        end
        if (due.status == ST_OVERFLOW) overflow_seen++;
        if (due.status == ST_UNDERFLOW) underflow_seen++;
        if (due.occupancy > peak_occupancy) peak_occupancy = due.occupancy;
      end
    end
  end

  // Watchdog: give up when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, op_results_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    req.valid      = 1'b0;
    req.op         = OP_PUSH_FRONT;
    req.value      = '0;
    rsp.ready      = 1'b0;
    stall_request  = 1'b0;
    hold_left      = 0;
    quiet_cycles   = 0;
    error_count    = 0;
    items_sent     = 0;
    results_seen   = 0;
    overflow_seen  = 0;
    underflow_seen = 0;
    peak_occupancy = 0;
    shadow_front   = 0;
    shadow_back    = 0;
    shadow_count   = 0;
    tx_idle_pct    = 13;
    rx_idle_pct    = 76;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender mostly busy, receiver mostly idle.
    test_empty_pops();
    test_extreme_words();
    test_fill_to_overflow();
    test_random_mix(180);

    // The other way round.
    tx_idle_pct = 76;
    rx_idle_pct <= 13;
    test_random_mix(180);

    // No idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    test_output_backpressure();
    test_random_mix(150);

    req.valid <= 1'b0;
    while (op_results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Ran %0d queue operations and checked %0d results.", items_sent, results_seen);
    $display("Saw %0d overflows, %0d underflows and a peak occupancy of %0d.",
             overflow_seen, underflow_seen, peak_occupancy);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
